// ===== design/rldt_pkg.sv =====
// rldt_pkg: shared constants and types for the recency loop detect table
// used by rldt_cell, rldt_max_tree and recency_loop_detect_table_unit
// no dependencies
package rldt_pkg;

	localparam int DEPTH    = 8;
	localparam int IDX_W    = $clog2(DEPTH + 1);
	localparam int TREE_LVL = $clog2(DEPTH);
	localparam int DEPTH_P2 = 1 << TREE_LVL;
	localparam int ID_W     = 32;
	localparam int STAMP_W  = 32;
	localparam int HITS_W   = 16;

	localparam logic [HITS_W-1:0] HITS_MAX    = {HITS_W{1'b1}};
	localparam logic [HITS_W-1:0] LIMIT_RESET = HITS_W'(16);

	localparam logic KIND_UPDATE = 1'b0;
	localparam logic KIND_ERASE  = 1'b1;

	typedef logic [IDX_W-1:0]   idx_t;
	typedef logic [ID_W-1:0]    id_t;
	typedef logic [STAMP_W-1:0] stamp_t;
	typedef logic [HITS_W-1:0]  hits_t;

	typedef struct packed {
		logic   valid;
		id_t    id;
		hits_t  hits;
		stamp_t stamp;
	} entry_t;

	// control broadcast to every cell in the commit cycle
	typedef struct packed {
		logic   commit;
		logic   erase;
		idx_t   rm_idx;   // slot that leaves the row, DEPTH when none
		entry_t ins;      // entry that goes in on an update
	} bcast_t;

endpackage

// ===== design/rldt_cell.sv =====
// rldt_cell: one slot of the recency table, shifts with its neighbors
// depends on rldt_pkg
module rldt_cell (
	input  logic             clk,
	input  logic             arst_n,
	input  rldt_pkg::idx_t   idx,
	input  logic             capture,
	input  rldt_pkg::id_t    key_id,
	input  rldt_pkg::stamp_t key_stamp,
	input  rldt_pkg::bcast_t bc,
	input  rldt_pkg::entry_t prev_ent,
	input  logic             prev_b,
	input  logic             prev_above,
	input  rldt_pkg::entry_t next_ent,
	input  logic             next_b,
	output rldt_pkg::entry_t ent,
	output logic             b,
	output logic             above,
	output logic             match_now,
	output rldt_pkg::hits_t  cand
);

	logic             valid_q;
	rldt_pkg::id_t    id_q;
	rldt_pkg::hits_t  hits_q;
	rldt_pkg::stamp_t stamp_q;
	logic             gt_s1;
	logic             eq_s1;
	logic             match_s1;

	logic             b_here;
	logic             b_prev;
	rldt_pkg::entry_t oth_here;
	rldt_pkg::entry_t oth_prev;
	rldt_pkg::entry_t nxt;

	assign ent       = '{valid: valid_q, id: id_q, hits: hits_q, stamp: stamp_q};
	assign match_now = valid_q && (id_q == key_id);
	assign above     = (idx < bc.rm_idx);
	// entry stays ahead of the inserted one: newer stamp, or equal and earlier
	assign b         = valid_q && (gt_s1 || (eq_s1 && above));
	assign cand      = (valid_q && !match_s1) ? hits_q : '0;

	// view of the row with the removed slot taken out
	assign b_here   = above ? b : next_b;
	assign b_prev   = prev_above ? prev_b : b;
	assign oth_here = above ? ent : next_ent;
	assign oth_prev = prev_above ? prev_ent : ent;

	always_comb begin
		priority if (bc.erase) begin
			nxt = oth_here;
		end else if (b_here) begin
			nxt = oth_here;
		end else if (b_prev) begin
			nxt = bc.ins;
		end else begin
			nxt = oth_prev;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (bc.commit) begin
			valid_q <= nxt.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bc.commit) begin
			id_q    <= nxt.id;
			hits_q  <= nxt.hits;
			stamp_q <= nxt.stamp;
		end
		if (capture) begin
			gt_s1    <= stamp_q > key_stamp;
			eq_s1    <= stamp_q == key_stamp;
			match_s1 <= match_now;
		end
	end

endmodule

// ===== design/rldt_max_tree.sv =====
// rldt_max_tree: maximum over the hit counts offered by the cells
// depends on rldt_pkg
module rldt_max_tree (
	input  rldt_pkg::hits_t cand [rldt_pkg::DEPTH],
	output rldt_pkg::hits_t max_out
);

	rldt_pkg::hits_t node [2*rldt_pkg::DEPTH_P2-1];

	genvar k;
	generate
		for (k = 0; k < rldt_pkg::DEPTH_P2; k++) begin : g_leaf
			if (k < rldt_pkg::DEPTH) begin : g_used
				assign node[rldt_pkg::DEPTH_P2-1+k] = cand[k];
			end else begin : g_pad
				assign node[rldt_pkg::DEPTH_P2-1+k] = '0;
			end
		end
		for (k = 0; k < rldt_pkg::DEPTH_P2-1; k++) begin : g_node
			assign node[k] = (node[2*k+1] > node[2*k+2]) ? node[2*k+1] : node[2*k+2];
		end
	endgenerate

	assign max_out = node[0];

endmodule

// ===== design/recency_loop_detect_table_unit.sv =====
// recency_loop_detect_table_unit: top level of the recency table with loop detect
// depends on rldt_pkg, rldt_cell, rldt_max_tree
//
//  channel  | handshake             | payload
//  ---------+-----------------------+--------------------------------
//  in       | in_valid / in_stall   | kind, item_id, stamp
//  out      | out_valid / out_stall | looping, max_hits, was_present
//  cfg      | cfg_we                | cfg_wdata (count_limit)
//
// per item, the transfer edge captures the id and stamp compares inside every cell,
// a later commit edge shifts the row and loads the result register; in_stall is
// high from the transfer until that commit
// a stalled result holds back the commit, the row shift and the next item
// reset empties the row at once through the cell valid bits, no clearing pass
module recency_loop_detect_table_unit (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic                    kind,
	input  logic [31:0]             item_id,
	input  logic [31:0]             stamp,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    looping,
	output logic [15:0]             max_hits,
	output logic                    was_present,
	input  logic                    cfg_we,
	input  logic [15:0]             cfg_wdata
);

	// control state
	logic busy_q;
	logic out_valid_q;
	logic loop_q;
	rldt_pkg::hits_t max_q;
	rldt_pkg::hits_t limit_q;

	// item captured at the input transfer
	logic             kind_s1;
	rldt_pkg::id_t    id_s1;
	rldt_pkg::stamp_t stamp_s1;
	rldt_pkg::idx_t   rm_s1;
	rldt_pkg::hits_t  hit_hits_s1;
	logic             hit_s1;

	// result register
	logic             looping_q;
	rldt_pkg::hits_t  max_hits_q;
	logic             was_present_q;

	// chain wiring
	rldt_pkg::entry_t ent_w   [rldt_pkg::DEPTH];
	logic             b_w     [rldt_pkg::DEPTH];
	logic             above_w [rldt_pkg::DEPTH];
	logic             match_w [rldt_pkg::DEPTH];
	rldt_pkg::hits_t  cand_w  [rldt_pkg::DEPTH];

	logic             capture;
	logic             commit;
	logic             hit_any;
	rldt_pkg::idx_t   hit_idx;
	rldt_pkg::hits_t  hit_hits;
	rldt_pkg::idx_t   rm_idx;
	rldt_pkg::hits_t  new_hits;
	rldt_pkg::hits_t  erase_max;
	rldt_pkg::hits_t  upd_max;
	rldt_pkg::hits_t  max_nxt;
	logic             loop_nxt;
	rldt_pkg::bcast_t bc;

	assign in_stall  = busy_q;
	assign capture   = in_valid && !in_stall;
	// commit only when the result register is free or being emptied
	assign commit    = busy_q && (!out_valid_q || !out_stall);

	assign out_valid   = out_valid_q;
	assign looping     = looping_q;
	assign max_hits    = max_hits_q;
	assign was_present = was_present_q;

	// ids are unique in the row, so the matching slot is found by or-ing
	always_comb begin
		hit_any  = 1'b0;
		hit_idx  = '0;
		hit_hits = '0;
		for (int i = 0; i < rldt_pkg::DEPTH; i++) begin
			if (match_w[i]) begin
				hit_any  = 1'b1;
				hit_idx  = hit_idx | rldt_pkg::idx_t'(i);
				hit_hits = hit_hits | ent_w[i].hits;
			end
		end
	end

	// leaving slot: the hit, the oldest on an update miss to a full row, else none
	always_comb begin
		if (hit_any) begin
			rm_idx = hit_idx;
		end else if ((kind == rldt_pkg::KIND_UPDATE) && ent_w[rldt_pkg::DEPTH-1].valid) begin
			rm_idx = rldt_pkg::idx_t'(rldt_pkg::DEPTH - 1);
		end else begin
			rm_idx = rldt_pkg::idx_t'(rldt_pkg::DEPTH);
		end
	end

	// saturating count for a hit, a new entry starts at one
	assign new_hits = !hit_s1 ? rldt_pkg::hits_t'(1) :
		(hit_hits_s1 == rldt_pkg::HITS_MAX) ? rldt_pkg::HITS_MAX :
		hit_hits_s1 + rldt_pkg::hits_t'(1);

	assign upd_max = (new_hits > max_q) ? new_hits : max_q;

	rldt_max_tree u_max_tree (
		.cand    (cand_w),
		.max_out (erase_max)
	);

	always_comb begin
		unique case (kind_s1)
			rldt_pkg::KIND_ERASE: begin
				max_nxt  = erase_max;
				loop_nxt = erase_max > limit_q;
			end
			default: begin
				if (hit_s1) begin
					// sticky flag, only raised on a hit
					max_nxt  = upd_max;
					loop_nxt = loop_q || (upd_max > limit_q);
				end else begin
					// insert keeps maximum and flag
					max_nxt  = max_q;
					loop_nxt = loop_q;
				end
			end
		endcase
	end

	assign bc = '{
		commit: commit,
		erase:  (kind_s1 == rldt_pkg::KIND_ERASE),
		rm_idx: rm_s1,
		ins:    '{valid: 1'b1, id: id_s1, hits: new_hits, stamp: stamp_s1}
	};

	// the row of cells, each sees its two neighbors
	genvar g;
	generate
		for (g = 0; g < rldt_pkg::DEPTH; g++) begin : g_cell
			rldt_pkg::entry_t prev_ent;
			logic             prev_b;
			logic             prev_above;
			rldt_pkg::entry_t next_ent;
			logic             next_b;

			if (g == 0) begin : g_head
				// a virtual slot ahead of the row that always stays in front
				assign prev_ent   = '0;
				assign prev_b     = 1'b1;
				assign prev_above = 1'b1;
			end else begin : g_mid_prev
				assign prev_ent   = ent_w[g-1];
				assign prev_b     = b_w[g-1];
				assign prev_above = above_w[g-1];
			end

			if (g == rldt_pkg::DEPTH - 1) begin : g_tail
				assign next_ent = '0;
				assign next_b   = 1'b0;
			end else begin : g_mid_next
				assign next_ent = ent_w[g+1];
				assign next_b   = b_w[g+1];
			end

			rldt_cell u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.idx        (rldt_pkg::idx_t'(g)),
				.capture    (capture),
				.key_id     (item_id),
				.key_stamp  (stamp),
				.bc         (bc),
				.prev_ent   (prev_ent),
				.prev_b     (prev_b),
				.prev_above (prev_above),
				.next_ent   (next_ent),
				.next_b     (next_b),
				.ent        (ent_w[g]),
				.b          (b_w[g]),
				.above      (above_w[g]),
				.match_now  (match_w[g]),
				.cand       (cand_w[g])
			);
		end
	endgenerate

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			loop_q      <= 1'b0;
			max_q       <= '0;
			limit_q     <= rldt_pkg::LIMIT_RESET;
		end else begin
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (capture) begin
				busy_q <= 1'b1;
			end else if (commit) begin
				busy_q <= 1'b0;
			end
			out_valid_q <= commit || (out_valid_q && out_stall);
			if (commit) begin
				loop_q <= loop_nxt;
				max_q  <= max_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (capture) begin
			kind_s1     <= kind;
			id_s1       <= item_id;
			stamp_s1    <= stamp;
			rm_s1       <= rm_idx;
			hit_hits_s1 <= hit_hits;
			hit_s1      <= hit_any;
		end
		if (commit) begin
			looping_q     <= loop_nxt;
			max_hits_q    <= max_nxt;
			was_present_q <= hit_s1;
		end
	end

endmodule

// ===== bench/tb_recency_loop_detect_table_unit.sv =====
// tb_recency_loop_detect_table_unit: self-checking bench for the recency table with loop detect
// depends on rldt_pkg and recency_loop_detect_table_unit; predicts each status and
// checks it against the block under random idling on both channels
module tb_recency_loop_detect_table_unit;
	timeunit 1ns;
	timeprecision 1ps;

	// one table operation as offered on the input channel
	typedef struct packed {
		logic             op_kind;
		rldt_pkg::id_t    id;
		rldt_pkg::stamp_t st;
	} op_t;

	// one status as returned on the output channel
	typedef struct packed {
		logic            looping;
		rldt_pkg::hits_t max_hits;
		logic            present;
	} status_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        in_valid  = 1'b0;
	logic        in_stall;
	logic        kind      = rldt_pkg::KIND_UPDATE;
	logic [31:0] item_id   = '0;
	logic [31:0] stamp     = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        looping;
	logic [15:0] max_hits;
	logic        was_present;
	logic        cfg_we    = 1'b0;
	logic [15:0] cfg_wdata = '0;

	recency_loop_detect_table_unit dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.kind       (kind),
		.item_id    (item_id),
		.stamp      (stamp),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.looping    (looping),
		.max_hits   (max_hits),
		.was_present(was_present),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	// 10 ns clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ops waiting for the driver, statuses waiting for the block
	op_t     pending_ops[$];
	status_t due_status[$];
	int      errors = 0;

	// zero all idling, used for the hit burst and a calm phase
	logic no_gaps = 1'b0;

	// long receiver hold-offs asked by the stimulus, served by the stall process
	int unsigned hold_requests = 0;
	int unsigned hold_served   = 0;

	// shadow copy of the table, newest first, used slots form a prefix
	rldt_pkg::id_t    row_id[rldt_pkg::DEPTH];
	rldt_pkg::hits_t  row_hits[rldt_pkg::DEPTH];
	rldt_pkg::stamp_t row_stamp[rldt_pkg::DEPTH];
	logic             row_used[rldt_pkg::DEPTH] = '{default: 1'b0};
	rldt_pkg::hits_t  peak            = '0;
	logic             looped          = 1'b0;
	rldt_pkg::hits_t  limit_q         = rldt_pkg::LIMIT_RESET;

	// gap length for either side: mostly none or short, now and then long
	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 45)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// apply one op to the shadow table and return the status it must produce
	function automatic status_t recency_update(op_t op);
		status_t          res;
		int               n;
		int               hit;
		int               i;
		int               j;
		rldt_pkg::id_t    tid;
		rldt_pkg::hits_t  th;
		rldt_pkg::stamp_t ts;
		n = 0;
		while (n < rldt_pkg::DEPTH && row_used[n])
			n++;
		hit = rldt_pkg::DEPTH;
		for (i = 0; i < n; i++)
			if (hit == rldt_pkg::DEPTH && row_id[i] == op.id)
				hit = i;
		if (op.op_kind == rldt_pkg::KIND_UPDATE) begin
			if (hit < rldt_pkg::DEPTH) begin
				// hit: saturating count, fresh stamp, max only rises, flag is sticky
				if (row_hits[hit] != rldt_pkg::HITS_MAX)
					row_hits[hit] = row_hits[hit] + rldt_pkg::hits_t'(1);
				row_stamp[hit] = op.st;
				if (row_hits[hit] > peak)
					peak = row_hits[hit];
				if (peak > limit_q)
					looped = 1'b1;
			end else begin
				// miss: oldest slot goes when full, max and flag untouched
				if (n >= rldt_pkg::DEPTH) begin
					n = rldt_pkg::DEPTH - 1;
					row_used[n] = 1'b0;
				end
				row_id[n]    = op.id;
				row_hits[n]  = 1;
				row_stamp[n] = op.st;
				row_used[n]  = 1'b1;
				n++;
			end
			// stable reorder by descending stamp, equal stamps keep their order
			for (i = 1; i < n; i++) begin
				tid = row_id[i];
				th  = row_hits[i];
				ts  = row_stamp[i];
				j   = i;
				while (j > 0 && row_stamp[j-1] < ts) begin
					row_id[j]    = row_id[j-1];
					row_hits[j]  = row_hits[j-1];
					row_stamp[j] = row_stamp[j-1];
					j--;
				end
				row_id[j]    = tid;
				row_hits[j]  = th;
				row_stamp[j] = ts;
			end
		end else begin
			// erase: close the gap, then rebuild max and flag from what is left
			if (hit < rldt_pkg::DEPTH) begin
				for (i = hit; i + 1 < n; i++) begin
					row_id[i]    = row_id[i+1];
					row_hits[i]  = row_hits[i+1];
					row_stamp[i] = row_stamp[i+1];
				end
				n--;
				row_used[n] = 1'b0;
			end
			peak = '0;
			for (i = 0; i < n; i++)
				if (row_hits[i] > peak)
					peak = row_hits[i];
			looped = (peak > limit_q);
		end
		res.looping  = looped;
		res.max_hits = peak;
		res.present  = (hit < rldt_pkg::DEPTH);
		return res;
	endfunction

	// input driver: a transfer is predicted at the edge where it happens,
	// the payload only moves on after a transfer or while idle
	op_t         cur_op;
	int unsigned send_gap = 0;

	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			send_gap = 0;
		end else begin
			if (in_valid && !in_stall)
				due_status.insert(due_status.size(), recency_update(cur_op));
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (pending_ops.size() != 0) begin
					cur_op = pending_ops.pop_front();
					kind     <= cur_op.op_kind;
					item_id  <= cur_op.id;
					stamp    <= cur_op.st;
					in_valid <= 1'b1;
					send_gap = pick_gap();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall: alternating stall and run stretches, plus long hold-offs
	int unsigned hold_left = 0;
	int unsigned seg_left  = 0;
	logic        seg_hold  = 1'b0;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			hold_left = 0;
			seg_left  = 0;
		end else begin
			if (hold_served != hold_requests) begin
				hold_served++;
				hold_left = 400;
			end
			if (hold_left != 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else if (no_gaps) begin
				out_stall <= 1'b0;
			end else begin
				if (seg_left == 0) begin
					seg_hold = !seg_hold;
					seg_left = seg_hold ? pick_gap() : $urandom_range(1, 12);
				end
				// an empty stall stretch just leaves the line low this cycle
				if (seg_left == 0) begin
					out_stall <= 1'b0;
				end else begin
					seg_left--;
					out_stall <= seg_hold;
				end
			end
		end
	end

	// monitor: each status transfer is checked against the oldest prediction
	always @(posedge clk) begin : monitor
		status_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (due_status.size() == 0) begin
				$display("%0t: status with none due: looping=%0b max_hits=%0d was_present=%0b",
					$time, looping, max_hits, was_present);
				errors++;
			end else begin
				want = due_status.pop_front();
				if (looping !== want.looping) begin
					$display("%0t: looping expected %0b actual %0b",
						$time, want.looping, looping);
					errors++;
				end
				if (max_hits !== want.max_hits) begin
					$display("%0t: max_hits expected %0d actual %0d",
						$time, want.max_hits, max_hits);
					errors++;
				end
				if (was_present !== want.present) begin
					$display("%0t: was_present expected %0b actual %0b",
						$time, want.present, was_present);
					errors++;
				end
			end
		end
	end

	// id pool so that random traffic keeps hitting the table
	rldt_pkg::id_t    id_pool[32];
	rldt_pkg::stamp_t stamp_clock = '0;

	task automatic push_op(logic k, rldt_pkg::id_t id, rldt_pkg::stamp_t st);
		op_t op;
		op.op_kind = k;
		op.id      = id;
		op.st      = st;
		pending_ops.insert(pending_ops.size(), op);
	endtask

	// wait until every op went out and every status came back,
	// looked at mid-cycle so that the edge updates have all landed
	task automatic settle();
		while (pending_ops.size() != 0 || in_valid || due_status.size() != 0)
			@(negedge clk);
		repeat (4) @(posedge clk);
	endtask

	// limit register write, only ever issued with the block idle
	task automatic write_limit(rldt_pkg::hits_t v);
		@(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		limit_q = v;
	endtask

	// one random phase: fresh pool, fresh limit, optional long hold-off
	task automatic run_phase(rldt_pkg::hits_t lim, int pool_n, int erase_pct, int count,
		bit long_hold);
		int               k;
		logic             op_k;
		rldt_pkg::id_t    id;
		rldt_pkg::stamp_t st;
		int               r;
		settle();
		write_limit(lim);
		for (k = 0; k < 32; k++)
			id_pool[k] = $urandom_range(0, 1) ? rldt_pkg::id_t'($urandom())
				: rldt_pkg::id_t'(k);
		id_pool[$urandom_range(0, pool_n - 1)] = '1;
		for (k = 0; k < count; k++) begin
			op_k = ($urandom_range(0, 99) < erase_pct) ? rldt_pkg::KIND_ERASE
				: rldt_pkg::KIND_UPDATE;
			id   = ($urandom_range(0, 9) != 0) ? id_pool[$urandom_range(0, pool_n - 1)]
				: rldt_pkg::id_t'($urandom());
			r = $urandom_range(0, 9);
			// mostly rising stamps with repeats, sometimes out of order
			if (r < 7) begin
				stamp_clock = stamp_clock + $urandom_range(0, 3);
				st = stamp_clock;
			end else if (r < 9) begin
				st = $urandom();
			end else begin
				st = stamp_clock;
			end
			push_op(op_k, id, st);
		end
		if (long_hold)
			hold_requests++;
	endtask

	initial begin : stimulus
		int            k;
		rldt_pkg::id_t burst_id;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: low limit so the flag comes up quickly
		write_limit(16'd2);
		push_op(rldt_pkg::KIND_ERASE, 32'h0, 32'h0);    // erase on empty table
		push_op(rldt_pkg::KIND_UPDATE, 32'h0, 32'h0);   // insert into empty table
		push_op(rldt_pkg::KIND_UPDATE, 32'h0, 32'h0);   // hit, count 2
		push_op(rldt_pkg::KIND_ERASE, 32'h0, 32'h0);    // erase of the only entry
		// insert with max at zero, then a hit with an equal stamp
		push_op(rldt_pkg::KIND_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		push_op(rldt_pkg::KIND_UPDATE, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		// count 3 over limit, older stamp
		push_op(rldt_pkg::KIND_UPDATE, 32'hFFFF_FFFF, 32'h1);
		// insert keeps max and flag
		push_op(rldt_pkg::KIND_UPDATE, 32'h5555_5555, 32'hAAAA_AAAA);
		// erase miss still recomputes
		push_op(rldt_pkg::KIND_ERASE, 32'h1234_5678, 32'h5555_5555);
		for (k = 0; k < 8; k++)                          // equal stamps, fill and evict
			push_op(rldt_pkg::KIND_UPDATE, 32'hAAAA_AAA0 + k, 32'h9);
		push_op(rldt_pkg::KIND_UPDATE, 32'hAAAA_AAA3, 32'h9);  // hit in a tie block
		push_op(rldt_pkg::KIND_ERASE, 32'hAAAA_AAA7, 32'h0);
		push_op(rldt_pkg::KIND_UPDATE, 32'h5555_5555, 32'h8);
		push_op(rldt_pkg::KIND_ERASE, 32'hFFFF_FFFF, 32'h0);

		// random phases over a spread of limits, extremes among them
		run_phase(16'd0, 3, 35, 280, 1'b0);
		run_phase(16'hFFFF, 12, 20, 280, 1'b1);
		run_phase(16'd1, 8, 25, 280, 1'b0);
		run_phase(rldt_pkg::hits_t'($urandom_range(3, 40)), 16, 15, 280, 1'b1);
		settle();
		no_gaps = 1'b1;
		run_phase(16'd5, 10, 25, 280, 1'b0);

		// hit burst: one id hit until its count passes a mid limit
		settle();
		write_limit(16'd30);
		burst_id = 32'hC0DE_5A7E;
		for (k = 0; k < 40; k++)
			push_op(rldt_pkg::KIND_UPDATE, burst_id, rldt_pkg::stamp_t'($urandom()));
		settle();
		// at the top limit no count can flag a loop
		write_limit(16'hFFFF);
		push_op(rldt_pkg::KIND_ERASE, 32'hFFFF_FFFE, 32'h0);
		push_op(rldt_pkg::KIND_UPDATE, burst_id, 32'h0);
		push_op(rldt_pkg::KIND_ERASE, burst_id, 32'h0);
		settle();
		no_gaps = 1'b0;

		repeat (20) @(posedge clk);
		if (errors == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// run limit, several times the slowest legal run
	initial begin
		#10ms;
		$display("status: fail");
		$finish;
	end

endmodule
